[hw/rtl/solar_charge_duty_regulator_top_defines.svh]
// Assertion macros shared by the regulator checker.
// Depends on a clk and rst signal in the scope that uses them.
`ifndef SOLAR_CHARGE_DUTY_REGULATOR_TOP_DEFINES_SVH
`define SOLAR_CHARGE_DUTY_REGULATOR_TOP_DEFINES_SVH

// Property checked on every edge outside reset.
`define SCDR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every edge, reset included.
`define SCDR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/scdr_pkg.sv]
// Types, constants and the solar target table for the charge duty regulator.
// No dependencies.
`timescale 1ns / 1ps

package scdr_pkg;

  localparam logic [14:0] CORR_MUL     = 15'd19;
  localparam logic [15:0] BATT_HIGH    = 16'd583;
  localparam logic [9:0]  TARGET_FLOOR = 10'd700;
  localparam logic [9:0]  TARGET_BATT  = 10'd540;
  localparam logic [9:0]  AMPS_MAX     = 10'd250;
  localparam logic [9:0]  AMPS_HYST    = 10'd195;
  localparam logic [9:0]  AMPS_STOP    = 10'd8;
  localparam logic [9:0]  FULL_VOLTS   = 10'd700;
  localparam logic [9:0]  BATT_HIGH_10 = 10'd583;
  localparam logic [2:0]  TARGET_IDX_MAX = 3'd5;

  // LED and battery-full request codes
  localparam logic [1:0] GREEN_KEEP = 2'd0;
  localparam logic [1:0] GREEN_OFF  = 2'd1;
  localparam logic [1:0] GREEN_ON   = 2'd2;
  localparam logic [1:0] FULL_KEEP  = 2'd0;
  localparam logic [1:0] FULL_SET   = 2'd1;
  localparam logic [1:0] FULL_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic REG_DUTY_FLOOR   = 1'b0;
  localparam logic REG_DUTY_CEILING = 1'b1;

  localparam logic [7:0] DUTY_FLOOR_RESET   = 8'd10;
  localparam logic [7:0] DUTY_CEILING_RESET = 8'd250;

  typedef struct packed {
    logic [9:0] battery_volts;
    logic [9:0] charge_amps;
    logic [9:0] solar_volts;
    logic [1:0] lamp_mode;
    logic       is_charging;
  } sample_t;

  typedef struct packed {
    logic [7:0] duty_now;
    logic       duty_applied;
    logic [1:0] green_led;
    logic       stop_charger;
    logic       long_sleep;
    logic [1:0] full_flag;
  } result_t;

  // Solar voltage target by current bucket
  function automatic logic [9:0] solar_target(input logic [2:0] idx);
    logic [9:0] t;
    case (idx)
      3'd0:    t = 10'd648;
      3'd1:    t = 10'd662;
      3'd2:    t = 10'd692;
      3'd3:    t = 10'd719;
      3'd4:    t = 10'd795;
      default: t = 10'd795;
    endcase
    return t;
  endfunction

endpackage

[hw/rtl/scdr_if.sv]
// Valid/ready channel interfaces for regulator samples and results.
// Depends on nothing; fields follow the sample and result layouts.
`timescale 1ns / 1ps

interface scdr_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] battery_volts;
  logic [9:0] charge_amps;
  logic [9:0] solar_volts;
  logic [1:0] lamp_mode;
  logic       is_charging;

  modport source (output valid, battery_volts, charge_amps, solar_volts, lamp_mode,
                  is_charging, input ready);
  modport sink (input valid, battery_volts, charge_amps, solar_volts, lamp_mode,
                is_charging, output ready);
endinterface

interface scdr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty_now;
  logic       duty_applied;
  logic [1:0] green_led;
  logic       stop_charger;
  logic       long_sleep;
  logic [1:0] full_flag;

  modport source (output valid, duty_now, duty_applied, green_led, stop_charger,
                  long_sleep, full_flag, input ready);
  modport sink (input valid, duty_now, duty_applied, green_led, stop_charger,
                long_sleep, full_flag, output ready);
endinterface

[hw/rtl/scdr_step.sv]
// Combinational duty update for one sample: correction, decisions, clamp.
// Depends on scdr_pkg.
`timescale 1ns / 1ps

module scdr_step (
  input  scdr_pkg::sample_t sample,
  input  logic [7:0]        charge_duty,
  input  logic [7:0]        duty_floor,
  input  logic [7:0]        duty_ceiling,
  output scdr_pkg::result_t result,
  output logic [7:0]        duty_next
);

  logic [14:0] amps_scaled;
  logic [15:0] corrected;
  logic        over_volt;
  logic        full_stop;
  logic [2:0]  target_idx;
  logic [9:0]  target_raw;
  logic [9:0]  target;
  logic [7:0]  duty_dec;
  logic [7:0]  duty_inc;
  logic [7:0]  adjusted;
  logic [7:0]  floored;
  logic [7:0]  clamped;
  logic [1:0]  green;
  logic [1:0]  full;

  assign amps_scaled = 15'(sample.charge_amps) * scdr_pkg::CORR_MUL;
  // 16-bit wrap: a negative correction reads as a large voltage
  assign corrected = 16'(sample.battery_volts) - 16'(amps_scaled[14:6]);
  assign over_volt = corrected > scdr_pkg::BATT_HIGH;
  assign full_stop = over_volt && (sample.charge_amps < scdr_pkg::AMPS_STOP);

  assign target_idx = (sample.charge_amps[9:4] > 6'(scdr_pkg::TARGET_IDX_MAX))
                      ? scdr_pkg::TARGET_IDX_MAX : sample.charge_amps[6:4];
  assign target_raw = scdr_pkg::solar_target(target_idx);
  assign target = (sample.battery_volts > scdr_pkg::TARGET_BATT &&
                   target_raw < scdr_pkg::TARGET_FLOOR) ? scdr_pkg::TARGET_FLOOR : target_raw;

  assign duty_dec = charge_duty - 8'd1;
  assign duty_inc = charge_duty + 8'd1;

  always_comb begin
    adjusted = charge_duty;
    green    = scdr_pkg::GREEN_KEEP;
    if (over_volt) begin
      green    = scdr_pkg::GREEN_OFF;
      adjusted = duty_dec;
    end else if (sample.charge_amps > scdr_pkg::AMPS_MAX) begin
      green    = scdr_pkg::GREEN_OFF;
      adjusted = duty_dec;
    end else if (sample.charge_amps < scdr_pkg::AMPS_HYST) begin
      if (sample.is_charging) begin
        green = scdr_pkg::GREEN_ON;
      end
      if (sample.solar_volts > target) begin
        adjusted = duty_inc;
      end else if (sample.solar_volts < target - 10'd2) begin
        adjusted = duty_dec;
      end
    end
  end

  // floor first, then ceiling: crossed bounds leave the ceiling in force
  assign floored = (adjusted < duty_floor) ? duty_floor : adjusted;
  assign clamped = (floored > duty_ceiling) ? duty_ceiling : floored;

  always_comb begin
    full = scdr_pkg::FULL_KEEP;
    if (sample.battery_volts >= scdr_pkg::FULL_VOLTS) begin
      full = scdr_pkg::FULL_SET;
    end
    if (sample.battery_volts <= scdr_pkg::BATT_HIGH_10) begin
      full = scdr_pkg::FULL_CLEAR;
    end
  end

  always_comb begin
    if (full_stop) begin
      duty_next           = charge_duty;
      result.duty_now     = charge_duty;
      result.duty_applied = 1'b0;
      result.green_led    = scdr_pkg::GREEN_OFF;
      result.stop_charger = 1'b1;
      result.long_sleep   = (sample.lamp_mode == 2'd0);
      result.full_flag    = scdr_pkg::FULL_SET;
    end else begin
      duty_next           = (sample.battery_volts >= scdr_pkg::FULL_VOLTS) ? 8'd0 : clamped;
      result.duty_now     = duty_next;
      result.duty_applied = 1'b1;
      result.green_led    = green;
      result.stop_charger = 1'b0;
      result.long_sleep   = 1'b0;
      result.full_flag    = full;
    end
  end

endmodule

[hw/rtl/solar_charge_duty_regulator_top.sv]
// Solar charge duty regulator: top level with sample register, result register
// and duty state. Depends on scdr_pkg, scdr_if.sv and scdr_step.
//
// Usage:
//  - samples: one transaction per ADC sample set (battery, current, solar,
//    lamp mode, charging flag). results: one transaction per sample, in order.
//  - cfg_write_en/cfg_index/cfg_data write duty_floor (index 0) or
//    duty_ceiling (index 1); write only while no sample is in flight.
//  - Path: an accepted sample is loaded into the sample register, then moves
//    into the result register when that slot frees up.
//  - Throughput: one sample per cycle while results.ready stays high. The duty
//    update is a single compare, step and clamp pass over the registered
//    sample, and charge_duty is written at the same edge as the result
//    register, so the next sample already sees the new duty.
//  - Stall: when results.ready is low the result register holds; the sample
//    register still fills, so one more sample is taken before samples.ready
//    drops.
//  - Reset (rst, synchronous): clear both valid flags and the duty to 0,
//    restore duty_floor to 10 and duty_ceiling to 250.
`timescale 1ns / 1ps

module solar_charge_duty_regulator_top (
  input  logic        clk,
  input  logic        rst,
  scdr_in_if.sink     samples,
  scdr_out_if.source  results,
  input  logic        cfg_write_en,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  scdr_pkg::sample_t sample;
  logic              sample_valid;
  scdr_pkg::result_t result;
  logic              result_valid;
  scdr_pkg::result_t step_result;
  logic [7:0]        duty_next;
  logic [7:0]        charge_duty;
  logic [7:0]        duty_floor;
  logic [7:0]        duty_ceiling;
  logic              advance;

  // Move the held sample into the result register when that slot frees up
  assign advance       = sample_valid && (!result_valid || results.ready);
  assign samples.ready = !sample_valid || advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_floor   <= scdr_pkg::DUTY_FLOOR_RESET;
      duty_ceiling <= scdr_pkg::DUTY_CEILING_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        scdr_pkg::REG_DUTY_FLOOR:   duty_floor   <= cfg_data;
        scdr_pkg::REG_DUTY_CEILING: duty_ceiling <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sample register: take a new transaction whenever the slot is empty or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (samples.ready) begin
      sample_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      sample.battery_volts <= samples.battery_volts;
      sample.charge_amps   <= samples.charge_amps;
      sample.solar_volts   <= samples.solar_volts;
      sample.lamp_mode     <= samples.lamp_mode;
      sample.is_charging   <= samples.is_charging;
    end
  end

  scdr_step u_step (
    .sample       (sample),
    .charge_duty  (charge_duty),
    .duty_floor   (duty_floor),
    .duty_ceiling (duty_ceiling),
    .result       (step_result),
    .duty_next    (duty_next)
  );

  // Duty state advances with each sample that moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      charge_duty <= 8'd0;
    end else if (advance) begin
      charge_duty <= duty_next;
    end
  end

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (results.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  assign results.valid        = result_valid;
  assign results.duty_now     = result.duty_now;
  assign results.duty_applied = result.duty_applied;
  assign results.green_led    = result.green_led;
  assign results.stop_charger = result.stop_charger;
  assign results.long_sleep   = result.long_sleep;
  assign results.full_flag    = result.full_flag;

endmodule

[hw/rtl/scdr_checker.sv]
// Port-level checks for the regulator, bound to the top level.
// Depends on scdr_pkg and solar_charge_duty_regulator_top_defines.svh.
`timescale 1ns / 1ps
`include "solar_charge_duty_regulator_top_defines.svh"

module scdr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] duty_now,
  input logic       duty_applied,
  input logic       stop_charger,
  input logic       long_sleep,
  input logic [1:0] full_flag
);

  `SCDR_ASSERT(a_stop_not_applied, out_valid && stop_charger |-> !duty_applied, "stop with duty applied")
  `SCDR_ASSERT(a_sleep_needs_stop, out_valid && long_sleep |-> stop_charger, "long sleep without stop")
  `SCDR_ASSERT(a_full_zero_duty, out_valid && duty_applied && (full_flag == scdr_pkg::FULL_SET) |-> (duty_now == 8'd0), "full battery with nonzero duty")
  `SCDR_ASSERT(a_result_holds, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `SCDR_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

endmodule

bind solar_charge_duty_regulator_top scdr_checker u_scdr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .duty_now     (results.duty_now),
  .duty_applied (results.duty_applied),
  .stop_charger (results.stop_charger),
  .long_sleep   (results.long_sleep),
  .full_flag    (results.full_flag)
);

[verif/tb_top.sv]
// Self-checking testbench for the solar charge duty regulator top level.
// Depends on scdr_pkg, the scdr_in_if/scdr_out_if interfaces and the RTL top.
`timescale 1ns / 1ps

module tb_top;
  import scdr_pkg::*;

  // An idle stretch with no transaction on any port that reaches STALL_LIMIT ends the run.
  localparam int STALL_LIMIT = 2000;

  typedef enum int {
    PATH_FULL_STOP,
    PATH_OVER_VOLTS,
    PATH_OVER_AMPS,
    PATH_BAND,
    PATH_TRACK_UP,
    PATH_TRACK_DOWN,
    PATH_TRACK_HOLD,
    PATH_COUNT
  } path_e;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  // One line of the directed table: either a sample or a register write.
  typedef struct {
    row_kind_e  kind;
    logic       reg_sel;
    logic [7:0] reg_value;
    sample_t    item;
    bit         typed;
    result_t    outcome;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic       cfg_write_en = 1'b0;
  logic       cfg_index = REG_DUTY_FLOOR;
  logic [7:0] cfg_data = 8'd0;

  scdr_in_if  samples ();
  scdr_out_if results ();

  solar_charge_duty_regulator_top dut (
    .clk          (clk),
    .rst          (rst),
    .samples      (samples),
    .results      (results),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow copy of the regulator state and its two bound registers.
  logic [7:0] model_duty;
  logic [7:0] model_floor;
  logic [7:0] model_ceiling;

  result_t duty_expect_q[$];
  row_t    stim_table[$];

  // Sideband from the sample driver: a directed row may carry its own answer.
  bit      pending_typed = 1'b0;
  result_t pending_outcome = '0;

  bit feed_gaps_on = 1'b0;
  bit drain_stalls_on = 1'b0;

  int mismatches = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int pressure_pauses = 0;
  int idle_cycles = 0;
  int path_hits[PATH_COUNT];

  // Work out one regulator step: compare, step the duty, clamp, full check.
  function automatic result_t predict_duty_step(input sample_t s, output path_e path);
    logic [14:0] amps_scaled;
    logic [15:0] corrected;
    logic [7:0]  duty;
    logic [9:0]  target;
    logic [5:0]  upper;
    logic [2:0]  bucket;
    result_t     r;
    amps_scaled = 15'(s.charge_amps) * 15'd19;
    corrected = 16'(s.battery_volts) - 16'(amps_scaled >> 6);
    duty = model_duty;
    r = '0;
    r.duty_applied = 1'b1;
    r.green_led = GREEN_KEEP;
    r.full_flag = FULL_KEEP;
    if (corrected > BATT_HIGH) begin
      // Over-voltage; a wrapped negative correction lands here too.
      r.green_led = GREEN_OFF;
      if (s.charge_amps < AMPS_STOP) begin
        // Full stop: duty held and reported, charger told to shut down.
        path = PATH_FULL_STOP;
        r.duty_now = model_duty;
        r.duty_applied = 1'b0;
        r.stop_charger = 1'b1;
        r.long_sleep = (s.lamp_mode == 2'd0);
        r.full_flag = FULL_SET;
        return r;
      end
      duty = duty - 8'd1;
      path = PATH_OVER_VOLTS;
    end else if (s.charge_amps > AMPS_MAX) begin
      r.green_led = GREEN_OFF;
      duty = duty - 8'd1;
      path = PATH_OVER_AMPS;
    end else if (s.charge_amps < AMPS_HYST) begin
      if (s.is_charging) r.green_led = GREEN_ON;
      upper = s.charge_amps[9:4];
      if (upper > 6'd5) bucket = TARGET_IDX_MAX;
      else bucket = upper[2:0];
      case (bucket)
        3'd0:    target = 10'd648;
        3'd1:    target = 10'd662;
        3'd2:    target = 10'd692;
        3'd3:    target = 10'd719;
        default: target = 10'd795;
      endcase
      if (s.battery_volts > TARGET_BATT && target < TARGET_FLOOR) target = TARGET_FLOOR;
      if (s.solar_volts > target) begin
        duty = duty + 8'd1;
        path = PATH_TRACK_UP;
      end else if (s.solar_volts < target - 10'd2) begin
        duty = duty - 8'd1;
        path = PATH_TRACK_DOWN;
      end else begin
        path = PATH_TRACK_HOLD;
      end
    end else begin
      path = PATH_BAND;
    end
    // Floor first, then ceiling: crossed bounds leave the ceiling in force.
    if (duty < model_floor) duty = model_floor;
    if (duty > model_ceiling) duty = model_ceiling;
    if (s.battery_volts >= FULL_VOLTS) begin
      r.full_flag = FULL_SET;
      duty = 8'd0;
    end
    if (s.battery_volts <= BATT_HIGH_10) r.full_flag = FULL_CLEAR;
    model_duty = duty;
    r.duty_now = duty;
    return r;
  endfunction

  function automatic row_t sample_row(input logic [9:0] batt, input logic [9:0] amps,
                                      input logic [9:0] solar, input logic [1:0] lamp,
                                      input logic chg);
    row_t r;
    r.kind = ROW_SAMPLE;
    r.reg_sel = REG_DUTY_FLOOR;
    r.reg_value = 8'd0;
    r.item = {batt, amps, solar, lamp, chg};
    r.typed = 1'b0;
    r.outcome = '0;
    return r;
  endfunction

  // Attach a hand-worked answer to a sample row.
  function automatic row_t known_row(input row_t r, input logic [7:0] duty,
                                     input logic applied, input logic [1:0] green,
                                     input logic stop, input logic sleep,
                                     input logic [1:0] full);
    row_t k;
    k = r;
    k.typed = 1'b1;
    k.outcome = {duty, applied, green, stop, sleep, full};
    return k;
  endfunction

  function automatic row_t write_row(input logic sel, input logic [7:0] value);
    row_t r;
    r = sample_row(10'd0, 10'd0, 10'd0, 2'd0, 1'b0);
    r.kind = ROW_WRITE;
    r.reg_sel = sel;
    r.reg_value = value;
    return r;
  endfunction

  // Random sample, mostly steered around the thresholds so every path is hit.
  function automatic sample_t random_sample();
    sample_t s;
    s.lamp_mode = 2'($urandom_range(0, 3));
    s.is_charging = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) < 2) begin
      s.battery_volts = 10'($urandom_range(0, 1023));
      s.charge_amps = 10'($urandom_range(0, 1023));
      s.solar_volts = 10'($urandom_range(0, 1023));
      return s;
    end
    case ($urandom_range(0, 3))
      0:       s.battery_volts = 10'($urandom_range(400, 583));
      1:       s.battery_volts = 10'($urandom_range(530, 699));
      2:       s.battery_volts = 10'($urandom_range(700, 1023));
      default: s.battery_volts = 10'($urandom_range(560, 640));
    endcase
    case ($urandom_range(0, 9))
      0:          s.charge_amps = 10'($urandom_range(0, 7));
      6, 7:       s.charge_amps = 10'($urandom_range(195, 250));
      8:          s.charge_amps = 10'($urandom_range(251, 1023));
      9:          s.charge_amps = 10'($urandom_range(185, 260));
      default:    s.charge_amps = 10'($urandom_range(8, 194));
    endcase
    s.solar_volts = 10'($urandom_range(620, 820));
    return s;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Drop valid and hold until every expected result is back, then let the
  // pipeline empty out before anything touches the registers.
  task automatic settle_block();
    samples.valid = 1'b0;
    while (duty_expect_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic sel, input logic [7:0] value);
    settle_block();
    cfg_write_en = 1'b1;
    cfg_index = sel;
    cfg_data = value;
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  // Present one sample from a falling edge and hold it until it is taken.
  task automatic send_sample(input sample_t item, input bit typed, input result_t outcome);
    int gap;
    if (feed_gaps_on && $urandom_range(0, 4) == 0) begin
      samples.valid = 1'b0;
      gap = $urandom_range(1, 14);
      repeat (gap) @(negedge clk);
    end
    samples.valid = 1'b1;
    samples.battery_volts = item.battery_volts;
    samples.charge_amps = item.charge_amps;
    samples.solar_volts = item.solar_volts;
    samples.lamp_mode = item.lamp_mode;
    samples.is_charging = item.is_charging;
    pending_typed = typed;
    pending_outcome = outcome;
    do @(posedge clk); while (!samples.ready);
    @(negedge clk);
  endtask

  // Drive the sample channel to known values from time zero.
  initial begin
    samples.valid = 1'b0;
    samples.battery_volts = 10'd0;
    samples.charge_amps = 10'd0;
    samples.solar_volts = 10'd0;
    samples.lamp_mode = 2'd0;
    samples.is_charging = 1'b0;
  end

  // Result-side back-pressure: random stall bursts while enabled.
  initial begin
    int n;
    results.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (drain_stalls_on && $urandom_range(0, 7) == 0) begin
        results.ready = 1'b0;
        n = $urandom_range(1, 14);
        repeat (n) @(negedge clk);
      end
      results.ready = 1'b1;
    end
  end

  // Predictor: track reset and register writes, and queue one expectation
  // per accepted sample transaction.
  always @(posedge clk) begin
    path_e   path;
    result_t pred;
    if (rst) begin
      model_duty = 8'd0;
      model_floor = DUTY_FLOOR_RESET;
      model_ceiling = DUTY_CEILING_RESET;
    end else begin
      if (cfg_write_en) begin
        if (cfg_index == REG_DUTY_FLOOR) model_floor = cfg_data;
        else model_ceiling = cfg_data;
        reg_writes++;
      end
      if (samples.valid && samples.ready) begin
        pred = predict_duty_step({samples.battery_volts, samples.charge_amps,
                                  samples.solar_volts, samples.lamp_mode,
                                  samples.is_charging}, path);
        path_hits[path]++;
        samples_sent++;
        // Directed rows with a hand-worked answer are checked against that.
        if (pending_typed) duty_expect_q.push_back(pending_outcome);
        else duty_expect_q.push_back(pred);
      end
    end
  end

  // Checker: compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && results.valid && results.ready) begin
      results_seen++;
      if (duty_expect_q.size() == 0) begin
        $error("result with no sample outstanding: duty_now %0d", results.duty_now);
        mismatches++;
      end else begin
        want = duty_expect_q.pop_front();
        check_field("duty_now", want.duty_now, results.duty_now);
        check_field("duty_applied", 8'(want.duty_applied), 8'(results.duty_applied));
        check_field("green_led", 8'(want.green_led), 8'(results.green_led));
        check_field("stop_charger", 8'(want.stop_charger), 8'(results.stop_charger));
        check_field("long_sleep", 8'(want.long_sleep), 8'(results.long_sleep));
        check_field("full_flag", 8'(want.full_flag), 8'(results.full_flag));
      end
    end
  end

  // Watchdog: any transaction or register write resets the count.
  always @(posedge clk) begin
    if ((samples.valid && samples.ready) || (results.valid && results.ready) || cfg_write_en)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int p;
    int k;
    int phase_items;
    int pause_at;
    logic [7:0] floor_v;
    logic [7:0] ceil_v;
    row_t row;

    // Hold reset from time zero, release on a falling edge.
    repeat (8) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed table. Starting from reset: duty 0, bounds 10..250.
    // Full stop with lamp off, then with lamp on and current just under the stop point.
    stim_table.push_back(known_row(sample_row(10'd600, 10'd0, 10'd0, 2'd0, 1'b0),
                                   8'd0, 1'b0, GREEN_OFF, 1'b1, 1'b1, FULL_SET));
    stim_table.push_back(known_row(sample_row(10'd1023, 10'd7, 10'd0, 2'd2, 1'b0),
                                   8'd0, 1'b0, GREEN_OFF, 1'b1, 1'b0, FULL_SET));
    // Correction larger than the reading wraps to over-voltage; 0-1 wraps, ceiling clamps.
    stim_table.push_back(known_row(sample_row(10'd0, 10'd1023, 10'd1023, 2'd3, 1'b1),
                                   8'd250, 1'b1, GREEN_OFF, 1'b0, 1'b0, FULL_CLEAR));
    // Over-current just past the limit.
    stim_table.push_back(known_row(sample_row(10'd583, 10'd251, 10'd0, 2'd1, 1'b1),
                                   8'd249, 1'b1, GREEN_OFF, 1'b0, 1'b0, FULL_CLEAR));
    // Both edges of the no-adjust current band.
    stim_table.push_back(known_row(sample_row(10'd300, 10'd195, 10'd512, 2'd0, 1'b1),
                                   8'd249, 1'b1, GREEN_KEEP, 1'b0, 1'b0, FULL_CLEAR));
    stim_table.push_back(known_row(sample_row(10'd584, 10'd250, 10'd0, 2'd2, 1'b0),
                                   8'd249, 1'b1, GREEN_KEEP, 1'b0, 1'b0, FULL_KEEP));
    // Full battery forces the duty to zero.
    stim_table.push_back(known_row(sample_row(10'd700, 10'd250, 10'd1023, 2'd1, 1'b1),
                                   8'd0, 1'b1, GREEN_OFF, 1'b0, 1'b0, FULL_SET));
    // Tracking: step up from zero lands on the floor.
    stim_table.push_back(known_row(sample_row(10'd500, 10'd0, 10'd1023, 2'd0, 1'b1),
                                   8'd10, 1'b1, GREEN_ON, 1'b0, 1'b0, FULL_CLEAR));
    // Battery above 540 raises the low targets; solar right at target holds.
    stim_table.push_back(known_row(sample_row(10'd541, 10'd16, 10'd700, 2'd0, 1'b0),
                                   8'd10, 1'b1, GREEN_KEEP, 1'b0, 1'b0, FULL_CLEAR));
    // Remaining table buckets and the step-down dead zone, left to the predictor.
    stim_table.push_back(sample_row(10'd541, 10'd16, 10'd697, 2'd1, 1'b1));
    stim_table.push_back(sample_row(10'd540, 10'd32, 10'd693, 2'd0, 1'b1));
    stim_table.push_back(sample_row(10'd583, 10'd48, 10'd719, 2'd2, 1'b0));
    stim_table.push_back(sample_row(10'd200, 10'd64, 10'd1023, 2'd3, 1'b1));
    stim_table.push_back(sample_row(10'd100, 10'd194, 10'd0, 2'd0, 1'b1));
    stim_table.push_back(sample_row(10'd1023, 10'd8, 10'd512, 2'd0, 1'b0));
    stim_table.push_back(sample_row(10'd699, 10'd0, 10'd0, 2'd0, 1'b0));
    stim_table.push_back(sample_row(10'd583, 10'd0, 10'd1023, 2'd1, 1'b1));
    // Pin the duty at 255, then let a step up wrap it to zero.
    stim_table.push_back(write_row(REG_DUTY_FLOOR, 8'd255));
    stim_table.push_back(write_row(REG_DUTY_CEILING, 8'd255));
    stim_table.push_back(known_row(sample_row(10'd300, 10'd200, 10'd0, 2'd0, 1'b0),
                                   8'd255, 1'b1, GREEN_KEEP, 1'b0, 1'b0, FULL_CLEAR));
    stim_table.push_back(write_row(REG_DUTY_FLOOR, 8'd0));
    stim_table.push_back(known_row(sample_row(10'd300, 10'd0, 10'd1023, 2'd0, 1'b0),
                                   8'd0, 1'b1, GREEN_KEEP, 1'b0, 1'b0, FULL_CLEAR));
    stim_table.push_back(known_row(sample_row(10'd300, 10'd300, 10'd0, 2'd0, 1'b0),
                                   8'd255, 1'b1, GREEN_OFF, 1'b0, 1'b0, FULL_CLEAR));
    // Crossed bounds: the ceiling wins.
    stim_table.push_back(write_row(REG_DUTY_FLOOR, 8'd200));
    stim_table.push_back(write_row(REG_DUTY_CEILING, 8'd100));
    stim_table.push_back(known_row(sample_row(10'd300, 10'd200, 10'd0, 2'd0, 1'b0),
                                   8'd100, 1'b1, GREEN_KEEP, 1'b0, 1'b0, FULL_CLEAR));
    stim_table.push_back(write_row(REG_DUTY_CEILING, 8'd0));
    stim_table.push_back(known_row(sample_row(10'd300, 10'd200, 10'd0, 2'd0, 1'b0),
                                   8'd0, 1'b1, GREEN_KEEP, 1'b0, 1'b0, FULL_CLEAR));

    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.kind == ROW_WRITE) write_register(row.reg_sel, row.reg_value);
      else send_sample(row.item, row.typed, row.outcome);
    end
    pending_typed = 1'b0;

    // Random phases: each one sets both bounds and its own idling mix.
    for (p = 0; p < 6; p++) begin
      pause_at = -1;
      case (p)
        0: begin
          floor_v = DUTY_FLOOR_RESET; ceil_v = DUTY_CEILING_RESET; phase_items = 110;
          feed_gaps_on = 1'b1; drain_stalls_on = 1'b1;
        end
        1: begin
          floor_v = 8'd0; ceil_v = 8'd255; phase_items = 100;
          feed_gaps_on = 1'b0; drain_stalls_on = 1'b0;
        end
        2: begin
          floor_v = 8'($urandom_range(0, 120)); ceil_v = 8'($urandom_range(130, 255));
          phase_items = 100; pause_at = 50;
          feed_gaps_on = 1'b1; drain_stalls_on = 1'b0;
        end
        3: begin
          floor_v = 8'($urandom_range(128, 255)); ceil_v = 8'($urandom_range(0, 127));
          phase_items = 50;
          feed_gaps_on = 1'b0; drain_stalls_on = 1'b1;
        end
        4: begin
          floor_v = 8'($urandom_range(0, 255)); ceil_v = 8'($urandom_range(0, 255));
          phase_items = 110; pause_at = 40;
          feed_gaps_on = 1'b1; drain_stalls_on = 1'b1;
        end
        default: begin
          // Closing stretch runs flat out with no idling on either side.
          floor_v = DUTY_FLOOR_RESET; ceil_v = DUTY_CEILING_RESET; phase_items = 80;
          feed_gaps_on = 1'b0; drain_stalls_on = 1'b0;
        end
      endcase
      write_register(REG_DUTY_FLOOR, floor_v);
      write_register(REG_DUTY_CEILING, ceil_v);
      for (k = 0; k < phase_items; k++) begin
        if (k == pause_at) begin
          // Hold the feed until the block has handed back everything.
          samples.valid = 1'b0;
          while (duty_expect_q.size() != 0) @(negedge clk);
          pressure_pauses++;
        end
        send_sample(random_sample(), 1'b0, '0);
      end
    end

    settle_block();

    $display("Regulator run: %0d samples, %0d results, %0d register writes, %0d drain pauses.",
             samples_sent, results_seen, reg_writes, pressure_pauses);
    $display("Paths: full stop %0d, over-volts %0d, over-amps %0d, band %0d, track %0d/%0d/%0d",
             path_hits[PATH_FULL_STOP], path_hits[PATH_OVER_VOLTS], path_hits[PATH_OVER_AMPS],
             path_hits[PATH_BAND], path_hits[PATH_TRACK_UP], path_hits[PATH_TRACK_DOWN],
             path_hits[PATH_TRACK_HOLD]);
    if (duty_expect_q.size() != 0) begin
      $error("%0d expected results never arrived", duty_expect_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
